// File: rtl/bfr_pkg.sv
// Package for the buffer frame replacement block: action codes, default
// sizes and the control struct of the victim compare unit.
// No dependencies.
package bfr_pkg;

  localparam int FRAMES_DEF     = 16;
  localparam int COUNT_BITS_DEF = 16;

  // Bound on the count: only a frame with a count below it is a candidate in the scan.
  localparam logic [32:0] SCAN_LIMIT = 33'h0FFFFFFFF;

  typedef enum logic [2:0] {
    ACT_TOUCH    = 3'd0,
    ACT_FILL     = 3'd1,
    ACT_MODIFIED = 3'd2,
    ACT_PIN      = 3'd3,
    ACT_UNPIN    = 3'd4,
    ACT_WB       = 3'd5,
    ACT_FREE     = 3'd6,
    ACT_ALLOC    = 3'd7
  } action_t;

  typedef struct packed {
    logic clear;    // start a new scan
    logic take;     // invalid frame found: it is the victim
    logic cmp_en;   // compare the count read for cmp index
    logic pinned;   // pinned mark of the compared frame
  } scan_ctl_t;

endpackage

// File: rtl/bfr_victim_sel.sv
// Compare unit of the allocate scan: keeps the smallest count of the
// unpinned frames seen and the frame that holds it. Depends on bfr_pkg.
module bfr_victim_sel #(
  parameter int IDX_W      = 4,
  parameter int COUNT_BITS = bfr_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bfr_pkg::scan_ctl_t    ctl,
  input  logic [IDX_W-1:0]      take_idx,
  input  logic [IDX_W-1:0]      cmp_idx,
  input  logic [COUNT_BITS-1:0] count,
  output logic [IDX_W-1:0]      victim
);

  logic                  have_best;
  logic [COUNT_BITS-1:0] best;
  logic                  cand;

  // Strict compare: the first frame wins a tie.
  always_comb begin
    if (have_best) begin
      cand = !ctl.pinned && (count < best);
    end else begin
      cand = !ctl.pinned && (33'(count) < bfr_pkg::SCAN_LIMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      have_best <= 1'b0;
      victim    <= '0;
    end else if (ctl.take) begin
      victim    <= take_idx;
    end else if (ctl.cmp_en && cand) begin
      have_best <= 1'b1;
      victim    <= cmp_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmp_en && cand) begin
      best <= count;
    end
  end

endmodule

// File: rtl/buffer_frame_replacement.sv
// Top level of the buffer frame replacement block: frame marks, access
// count memory and the event sequencer. Depends on bfr_pkg, bfr_victim_sel.
//
//   channel | handshake          | payload
//   --------+--------------------+-------------------------------------
//   in      | in_valid, in_stall | action, frame, fill_modified
//   out     | out_valid,out_stall| chosen_frame, write_back, status
//
// Touch runs S_EXEC and S_TOUCH before S_DONE, the other frame actions
// S_EXEC only. Allocate runs S_SCAN, S_DRAIN and S_APPLY; an invalid
// frame found skips S_DRAIN. The scan reads one count a cycle through the
// single read port of the count memory into one comparator. Reset clears
// every mark and the per-entry count valid bits at once; no clearing pass.
// in_stall is high from a transfer until the result is loaded into the
// output register; a stalled result only holds up loading the next one.
module buffer_frame_replacement #(
  parameter int FRAMES     = bfr_pkg::FRAMES_DEF,
  parameter int COUNT_BITS = bfr_pkg::COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] action,
  input  logic [3:0] frame,
  input  logic       fill_modified,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] chosen_frame,
  output logic       write_back,
  output logic       status
);

  localparam int IDX_W = $clog2(FRAMES);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXEC  = 7'b0000010,
    S_TOUCH = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_DRAIN = 7'b0010000,
    S_APPLY = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [FRAMES-1:0] valid_mark, pinned_mark, modified_mark, count_ok;
  logic [COUNT_BITS-1:0] count_mem [FRAMES];
  logic [COUNT_BITS-1:0] rd_data;
  logic                  rd_ok;
  logic [COUNT_BITS-1:0] rd_count;
  logic [IDX_W-1:0]      rd_addr;

  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;

  bfr_pkg::action_t lat_act;
  logic [3:0]       lat_frame;
  logic             lat_fm;
  logic [IDX_W-1:0] faddr;
  logic             in_range;

  logic [IDX_W-1:0] scan_idx, cmp_idx, victim;
  logic             cmp_pend;
  logic             scan_last;
  bfr_pkg::scan_ctl_t scan_ctl;

  logic [3:0] res_frame;
  logic       res_wb, res_st;
  logic       in_xfer, out_load;

  assign in_stall  = (state != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_load  = (state == S_DONE) && (!out_valid || !out_stall);
  assign faddr     = IDX_W'(lat_frame);
  assign in_range  = (32'(lat_frame) < 32'(FRAMES));
  assign scan_last = (scan_idx == IDX_W'(FRAMES - 1));
  assign rd_addr   = (state == S_SCAN) ? scan_idx : faddr;
  assign rd_count  = rd_ok ? rd_data : '0;

  // Count memory: an entry whose ok bit is clear reads as zero.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      count_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= count_mem[rd_addr];
    rd_ok   <= count_ok[rd_addr];
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = faddr;
    mem_wdata = '0;
    if (state == S_EXEC && in_range && lat_act == bfr_pkg::ACT_FILL) begin
      mem_we    = 1'b1;
      mem_wdata = COUNT_BITS'(1);
    end else if (state == S_TOUCH && rd_count != {COUNT_BITS{1'b1}}) begin
      mem_we    = 1'b1;
      mem_wdata = rd_count + COUNT_BITS'(1);
    end
  end

  always_comb begin
    scan_ctl.clear  = in_xfer;
    scan_ctl.take   = (state == S_SCAN) && !valid_mark[scan_idx];
    scan_ctl.cmp_en = ((state == S_SCAN) || (state == S_DRAIN)) && cmp_pend;
    scan_ctl.pinned = pinned_mark[cmp_idx];
  end

  bfr_victim_sel #(
    .IDX_W      (IDX_W),
    .COUNT_BITS (COUNT_BITS)
  ) u_sel (
    .clk      (clk),
    .rst      (rst),
    .ctl      (scan_ctl),
    .take_idx (scan_idx),
    .cmp_idx  (cmp_idx),
    .count    (rd_count),
    .victim   (victim)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          state_next = (bfr_pkg::action_t'(action) == bfr_pkg::ACT_ALLOC) ? S_SCAN : S_EXEC;
        end
      end
      S_EXEC: begin
        if (in_range && lat_act == bfr_pkg::ACT_TOUCH) begin
          state_next = S_TOUCH;
        end else begin
          state_next = S_DONE;
        end
      end
      S_TOUCH: state_next = S_DONE;
      S_SCAN: begin
        if (!valid_mark[scan_idx]) begin
          state_next = S_APPLY;
        end else if (scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_APPLY;
      S_APPLY: state_next = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cmp_pend  <= 1'b0;
    end else begin
      state    <= state_next;
      cmp_pend <= (state == S_SCAN) && valid_mark[scan_idx];
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Frame marks and count ok bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_mark    <= '0;
      pinned_mark   <= '0;
      modified_mark <= '0;
      count_ok      <= '0;
    end else begin
      if (mem_we) begin
        count_ok[mem_waddr] <= 1'b1;
      end
      if (state == S_EXEC && in_range) begin
        case (lat_act)
          bfr_pkg::ACT_FILL: begin
            valid_mark[faddr]    <= 1'b1;
            modified_mark[faddr] <= lat_fm;
          end
          bfr_pkg::ACT_MODIFIED: modified_mark[faddr] <= 1'b1;
          bfr_pkg::ACT_PIN:      pinned_mark[faddr]   <= 1'b1;
          bfr_pkg::ACT_UNPIN:    pinned_mark[faddr]   <= 1'b0;
          bfr_pkg::ACT_WB: begin
            count_ok[faddr]      <= 1'b0;
            modified_mark[faddr] <= 1'b0;
            valid_mark[faddr]    <= 1'b0;
          end
          bfr_pkg::ACT_FREE: begin
            if (!pinned_mark[faddr]) begin
              valid_mark[faddr]    <= 1'b0;
              modified_mark[faddr] <= 1'b0;
            end
          end
          default: ;
        endcase
      end
      if (state == S_APPLY) begin
        // Write-back of a dirty victim drops its count, then free it.
        if (valid_mark[victim] && modified_mark[victim]) begin
          count_ok[victim] <= 1'b0;
        end
        if (!pinned_mark[victim]) begin
          valid_mark[victim]    <= 1'b0;
          modified_mark[victim] <= 1'b0;
        end else if (valid_mark[victim] && modified_mark[victim]) begin
          valid_mark[victim]    <= 1'b0;
          modified_mark[victim] <= 1'b0;
        end
      end
    end
  end

  // Latched event, scan position and result.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      lat_act   <= bfr_pkg::action_t'(action);
      lat_frame <= frame;
      lat_fm    <= fill_modified;
      res_frame <= frame;
      res_wb    <= 1'b0;
      res_st    <= 1'b0;
      scan_idx  <= '0;
    end
    if (state == S_SCAN) begin
      cmp_idx <= scan_idx;
      if (!scan_last) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
    end
    if (state == S_EXEC && in_range) begin
      if (lat_act == bfr_pkg::ACT_WB) begin
        res_wb <= modified_mark[faddr];
      end
      if (lat_act == bfr_pkg::ACT_FREE) begin
        res_st <= pinned_mark[faddr];
      end
    end
    if (state == S_APPLY) begin
      res_frame <= 4'(victim);
      res_wb    <= valid_mark[victim] && modified_mark[victim];
      res_st    <= pinned_mark[victim];
    end
    if (out_load) begin
      chosen_frame <= res_frame;
      write_back   <= res_wb;
      status       <= res_st;
    end
  end

endmodule

// File: rtl/bfr_checker.sv
// Port-level checks of the buffer frame replacement block, bound to the
// top level. Depends on nothing but the top level's ports.
module bfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] chosen_frame,
  input logic       write_back,
  input logic       status
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(chosen_frame)
      && $stable(write_back) && $stable(status))
    else $error("stalled result changed");

  // Stay busy right after taking an event.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("event taken while busy");

  // A result never appears at once on taking an event.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");

  // Come out of reset idle with no result.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind buffer_frame_replacement bfr_checker u_bfr_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .chosen_frame (chosen_frame),
  .write_back   (write_back),
  .status       (status)
);
